>>> sv/drst_pkg.sv
// drst_pkg: shared types and constants of the deduplicating slot table
// used by drst_ctrl, drst_dp and dedup_refcount_slot_table; no dependencies
package drst_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = 8;
  localparam int MARK_W = 9;

  localparam logic [1:0]  KIND_THIRTY_TWO = 2'd1;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_SHARED    = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_FREED     = 3'd4,
    ST_IGNORED   = 3'd5,
    ST_READ_OK   = 3'd6,
    ST_READ_DEAD = 3'd7
  } status_t;

  typedef struct packed {
    logic [31:0] first_idx;
    logic [31:0] idx_count;
    logic [31:0] vtx_base;
    logic [31:0] vtx_count;
    logic [15:0] segment;
    logic [1:0]  kind;
  } rec_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_HIT,
    CMD_ALLOC,
    CMD_UNREG,
    CMD_READ,
    CMD_IGNORE,
    CMD_SHRINK,
    CMD_COMPACT,
    CMD_EMIT
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_HIT,
    S_ALLOC,
    S_SHRINK,
    S_COMPACT,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic scan_hit;
    logic scan_miss;
    logic free_top;
    logic shrink_done;
    logic compact_done;
  } dp_stat_t;

endpackage

>>> sv/dedup_refcount_slot_table.sv
// dedup_refcount_slot_table: top level of the deduplicating slot table
// depends on drst_pkg, drst_ctrl and drst_dp
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_stall  | op, record fields, segment, index_kind, slot_id
//   out     | out_valid / out_stall| status, result_id, refs_now, watermark, record
//
// read, unregister that does not free the top slot, unused op: load, dispatch, emit
// register: adds the key scan at one slot a cycle below the watermark, then hit or allocate
// freeing the top slot: adds one shrink step per dead tail slot dropped, then
// the free-stack compaction
// reset is synchronous; the table comes up empty with no clearing pass
// in_stall is high from acceptance until the result is loaded; out_stall holds it
module dedup_refcount_slot_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [31:0]        first_idx,
  input  logic [31:0]        idx_count,
  input  logic signed [31:0] vtx_base,
  input  logic [31:0]        vtx_count,
  input  logic [15:0]        segment,
  input  logic [1:0]         index_kind,
  input  logic [7:0]         slot_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [7:0]         result_id,
  output logic [31:0]        refs_now,
  output logic [8:0]         watermark,
  output logic [31:0]        out_first_idx,
  output logic [31:0]        out_idx_count,
  output logic signed [31:0] out_vtx_base,
  output logic [31:0]        out_vtx_count,
  output logic [15:0]        out_segment,
  output logic [1:0]         out_index_kind
);

  drst_pkg::cmd_t     cmd;
  drst_pkg::dp_stat_t stat;

  // sequencer
  drst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table storage and result path
  drst_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .first_idx      (first_idx),
    .idx_count      (idx_count),
    .vtx_base       (vtx_base),
    .vtx_count      (vtx_count),
    .segment        (segment),
    .index_kind     (index_kind),
    .slot_id        (slot_id),
    .status         (status),
    .result_id      (result_id),
    .refs_now       (refs_now),
    .watermark      (watermark),
    .out_first_idx  (out_first_idx),
    .out_idx_count  (out_idx_count),
    .out_vtx_base   (out_vtx_base),
    .out_vtx_count  (out_vtx_count),
    .out_segment    (out_segment),
    .out_index_kind (out_index_kind)
  );

endmodule

>>> sv/drst_ctrl.sv
// drst_ctrl: sequencing state machine of the slot table
// depends on drst_pkg; drives commands into drst_dp
module drst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  drst_pkg::dp_stat_t stat,
  output drst_pkg::cmd_t     cmd
);

  drst_pkg::state_t state, state_next;
  logic             out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= drst_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != drst_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = drst_pkg::CMD_NONE;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      drst_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd        = drst_pkg::CMD_LOAD;
          state_next = drst_pkg::S_DISPATCH;
        end
      end
      drst_pkg::S_DISPATCH: begin
        unique case (stat.op)
          drst_pkg::OP_REG: state_next = drst_pkg::S_SCAN;
          drst_pkg::OP_UNREG: begin
            cmd        = drst_pkg::CMD_UNREG;
            state_next = stat.free_top ? drst_pkg::S_SHRINK : drst_pkg::S_EMIT;
          end
          drst_pkg::OP_READ: begin
            cmd        = drst_pkg::CMD_READ;
            state_next = drst_pkg::S_EMIT;
          end
          default: begin
            cmd        = drst_pkg::CMD_IGNORE;
            state_next = drst_pkg::S_EMIT;
          end
        endcase
      end
      drst_pkg::S_SCAN: begin
        cmd = drst_pkg::CMD_SCAN;
        priority if (stat.scan_hit) state_next = drst_pkg::S_HIT;
        else if (stat.scan_miss)    state_next = drst_pkg::S_ALLOC;
        else                        state_next = drst_pkg::S_SCAN;
      end
      drst_pkg::S_HIT: begin
        cmd        = drst_pkg::CMD_HIT;
        state_next = drst_pkg::S_EMIT;
      end
      drst_pkg::S_ALLOC: begin
        cmd        = drst_pkg::CMD_ALLOC;
        state_next = drst_pkg::S_EMIT;
      end
      drst_pkg::S_SHRINK: begin
        if (stat.shrink_done) state_next = drst_pkg::S_COMPACT;
        else                  cmd = drst_pkg::CMD_SHRINK;
      end
      drst_pkg::S_COMPACT: begin
        cmd = drst_pkg::CMD_COMPACT;
        if (stat.compact_done) state_next = drst_pkg::S_EMIT;
      end
      drst_pkg::S_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd            = drst_pkg::CMD_EMIT;
          out_valid_next = 1'b1;
          state_next     = drst_pkg::S_IDLE;
        end
      end
      default: state_next = drst_pkg::S_IDLE;
    endcase
  end

endmodule

>>> sv/drst_dp.sv
// drst_dp: slot memories, live bits, free stack, watermark and result registers
// depends on drst_pkg; commanded by drst_ctrl
module drst_dp (
  input  logic               clk,
  input  logic               rst,
  input  drst_pkg::cmd_t     cmd,
  output drst_pkg::dp_stat_t stat,
  input  logic [1:0]         op,
  input  logic [31:0]        first_idx,
  input  logic [31:0]        idx_count,
  input  logic signed [31:0] vtx_base,
  input  logic [31:0]        vtx_count,
  input  logic [15:0]        segment,
  input  logic [1:0]         index_kind,
  input  logic [7:0]         slot_id,
  output logic [2:0]         status,
  output logic [7:0]         result_id,
  output logic [31:0]        refs_now,
  output logic [8:0]         watermark,
  output logic [31:0]        out_first_idx,
  output logic [31:0]        out_idx_count,
  output logic signed [31:0] out_vtx_base,
  output logic [31:0]        out_vtx_count,
  output logic [15:0]        out_segment,
  output logic [1:0]         out_index_kind
);

  // memories
  drst_pkg::rec_t rec_mem [drst_pkg::SLOTS];
  logic [31:0]    ref_mem [drst_pkg::SLOTS];
  logic [7:0]     stk_mem [drst_pkg::SLOTS];

  drst_pkg::rec_t rec_q;
  logic [31:0]    ref_q;
  logic [7:0]     stk_q;

  // control state
  logic [drst_pkg::SLOTS-1:0] live;
  logic [8:0] hm, fd;
  logic [8:0] issue_idx, cidx, kpos;
  logic [7:0] cmp_idx;
  logic       cmp_valid, cpend;

  // captured item
  drst_pkg::op_t  op_q;
  drst_pkg::rec_t key_q;
  logic [7:0]     sid_q;

  // staged result
  logic [2:0]     res_status;
  logic [7:0]     res_id;
  logic [31:0]    res_refs;
  drst_pkg::rec_t res_rec;

  // memory port controls
  logic           rec_rd, rec_wr, stk_rd, stk_wr, ref_wr;
  logic [7:0]     rec_raddr, rec_waddr, stk_raddr, stk_waddr;
  logic [7:0]     stk_wdata;
  logic [31:0]    ref_wdata;

  // decode helpers
  logic       match, issue, unreg_ok, free_top, cdone, alloc_ok;
  logic [31:0] ref_dec;
  logic [7:0]  alloc_id;
  logic [8:0]  hm_dec, id_ext;

  assign match    = live[cmp_idx] && (rec_q == key_q);
  assign issue    = (issue_idx < hm) && !(cmp_valid && match);
  assign unreg_ok = live[sid_q] && (ref_q != 32'd0);
  assign ref_dec  = ref_q - 32'd1;
  assign free_top = unreg_ok && (ref_dec == 32'd0) && (({1'b0, sid_q} + 9'd1) == hm);
  assign hm_dec   = hm - 9'd1;
  assign cdone    = !cpend && (cidx >= fd);
  assign alloc_ok = (fd != 9'd0) || (hm < 9'(drst_pkg::SLOTS));
  assign alloc_id = (fd != 9'd0) ? stk_q : hm[7:0];
  assign id_ext   = {1'b0, alloc_id};

  assign stat.op           = op_q;
  assign stat.scan_hit     = cmp_valid && match;
  assign stat.scan_miss    = !cmp_valid && (issue_idx >= hm);
  assign stat.free_top     = free_top;
  assign stat.shrink_done  = (hm == 9'd0) || live[hm_dec[7:0]];
  assign stat.compact_done = cdone;

  // memory port selection
  always_comb begin
    rec_rd    = 1'b0;
    rec_raddr = sid_q;
    rec_wr    = 1'b0;
    rec_waddr = alloc_id;
    ref_wr    = 1'b0;
    ref_wdata = 32'd1;
    stk_rd    = 1'b0;
    stk_raddr = cidx[7:0];
    stk_wr    = 1'b0;
    stk_waddr = kpos[7:0];
    stk_wdata = stk_q;
    unique case (cmd)
      drst_pkg::CMD_LOAD: begin
        rec_rd    = 1'b1;
        rec_raddr = slot_id;
        stk_rd    = 1'b1;
        stk_raddr = 8'(fd - 9'd1);
      end
      drst_pkg::CMD_SCAN: begin
        rec_rd    = issue;
        rec_raddr = issue_idx[7:0];
      end
      drst_pkg::CMD_HIT: begin
        ref_wr    = (ref_q != drst_pkg::COUNT_MAX);
        ref_wdata = ref_q + 32'd1;
        rec_waddr = cmp_idx;
      end
      drst_pkg::CMD_ALLOC: begin
        rec_wr = alloc_ok;
        ref_wr = alloc_ok;
      end
      drst_pkg::CMD_UNREG: begin
        ref_wr    = unreg_ok;
        ref_wdata = ref_dec;
        rec_waddr = sid_q;
        stk_wr    = unreg_ok && (ref_dec == 32'd0) && !fd[8];
        stk_waddr = fd[7:0];
        stk_wdata = sid_q;
      end
      drst_pkg::CMD_COMPACT: begin
        stk_rd = !(cidx >= fd);
        stk_wr = cpend && ({1'b0, stk_q} < hm);
      end
      default: ;
    endcase
  end

  // record and count memories share the address of each access
  always_ff @(posedge clk) begin
    if (rec_wr) rec_mem[rec_waddr] <= key_q;
    if (ref_wr) ref_mem[rec_waddr] <= ref_wdata;
    if (rec_rd) begin
      rec_q <= rec_mem[rec_raddr];
      ref_q <= ref_mem[rec_raddr];
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (stk_wr) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_rd) stk_q <= stk_mem[stk_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      hm        <= 9'd0;
      fd        <= 9'd0;
      cmp_valid <= 1'b0;
      cpend     <= 1'b0;
      issue_idx <= 9'd0;
      cidx      <= 9'd0;
      kpos      <= 9'd0;
    end else begin
      unique case (cmd)
        drst_pkg::CMD_LOAD: begin
          issue_idx <= 9'd0;
          cmp_valid <= 1'b0;
        end
        drst_pkg::CMD_SCAN: begin
          cmp_valid <= issue;
          if (issue) begin
            issue_idx <= issue_idx + 9'd1;
            cmp_idx   <= issue_idx[7:0];
          end
        end
        drst_pkg::CMD_ALLOC: begin
          if (alloc_ok) begin
            live[alloc_id] <= 1'b1;
            if (fd != 9'd0) begin
              fd <= fd - 9'd1;
              if (id_ext >= hm) hm <= id_ext + 9'd1;
            end else begin
              hm <= hm + 9'd1;
            end
          end
        end
        drst_pkg::CMD_UNREG: begin
          if (unreg_ok && ref_dec == 32'd0) begin
            live[sid_q] <= 1'b0;
            if (!fd[8]) fd <= fd + 9'd1;
            cidx  <= 9'd0;
            kpos  <= 9'd0;
            cpend <= 1'b0;
          end
        end
        drst_pkg::CMD_SHRINK: hm <= hm_dec;
        drst_pkg::CMD_COMPACT: begin
          if (stk_wr) kpos <= kpos + 9'd1;
          cpend <= stk_rd;
          if (stk_rd) cidx <= cidx + 9'd1;
          if (cdone) fd <= kpos;
        end
        default: ;
      endcase
    end
  end

  // item capture and staged result
  always_ff @(posedge clk) begin
    unique case (cmd)
      drst_pkg::CMD_LOAD: begin
        op_q            <= drst_pkg::op_t'(op);
        sid_q           <= slot_id;
        key_q.first_idx <= first_idx;
        key_q.idx_count <= idx_count;
        key_q.vtx_base  <= vtx_base;
        key_q.vtx_count <= vtx_count;
        key_q.segment   <= segment;
        key_q.kind      <= index_kind;
        res_rec         <= '{kind: drst_pkg::KIND_THIRTY_TWO, default: '0};
      end
      drst_pkg::CMD_HIT: begin
        if (ref_q == drst_pkg::COUNT_MAX) begin
          res_status <= drst_pkg::ST_REFUSED;
          res_id     <= 8'd0;
          res_refs   <= 32'd0;
        end else begin
          res_status <= drst_pkg::ST_SHARED;
          res_id     <= cmp_idx;
          res_refs   <= ref_q + 32'd1;
        end
      end
      drst_pkg::CMD_ALLOC: begin
        res_status <= alloc_ok ? drst_pkg::ST_NEW : drst_pkg::ST_REFUSED;
        res_id     <= alloc_ok ? alloc_id : 8'd0;
        res_refs   <= alloc_ok ? 32'd1 : 32'd0;
      end
      drst_pkg::CMD_UNREG: begin
        res_id <= sid_q;
        priority if (!unreg_ok) begin
          res_status <= drst_pkg::ST_IGNORED;
          res_refs   <= 32'd0;
        end else if (ref_dec != 32'd0) begin
          res_status <= drst_pkg::ST_RELEASED;
          res_refs   <= ref_dec;
        end else begin
          res_status <= drst_pkg::ST_FREED;
          res_refs   <= 32'd0;
        end
      end
      drst_pkg::CMD_READ: begin
        res_id <= sid_q;
        if (live[sid_q]) begin
          res_status <= drst_pkg::ST_READ_OK;
          res_refs   <= ref_q;
          res_rec    <= rec_q;
        end else begin
          res_status <= drst_pkg::ST_READ_DEAD;
          res_refs   <= 32'd0;
        end
      end
      drst_pkg::CMD_IGNORE: begin
        res_status <= drst_pkg::ST_IGNORED;
        res_id     <= sid_q;
        res_refs   <= 32'd0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd == drst_pkg::CMD_EMIT) begin
      status         <= res_status;
      result_id      <= res_id;
      refs_now       <= res_refs;
      watermark      <= hm;
      out_first_idx  <= res_rec.first_idx;
      out_idx_count  <= res_rec.idx_count;
      out_vtx_base   <= signed'(res_rec.vtx_base);
      out_vtx_count  <= res_rec.vtx_count;
      out_segment    <= res_rec.segment;
      out_index_kind <= res_rec.kind;
    end
  end

endmodule

>>> test/tb_dedup_refcount_slot_table.sv
// tb_dedup_refcount_slot_table: self-checking bench for the dedup slot table
// depends on drst_pkg and dedup_refcount_slot_table
module tb_dedup_refcount_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    drst_pkg::op_t  op;
    drst_pkg::rec_t rec;
    logic [7:0]     sid;
  } req_t;

  typedef struct packed {
    drst_pkg::status_t st;
    logic [7:0]        id;
    logic [31:0]       refs;
    logic [8:0]        mark;
    drst_pkg::rec_t    rec;
  } resp_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] op, index_kind;
  logic [31:0] first_idx, idx_count, vtx_count;
  logic signed [31:0] vtx_base, out_vtx_base;
  logic [15:0] segment, out_segment;
  logic [7:0] slot_id, result_id;
  logic [2:0] status;
  logic [31:0] refs_now, out_first_idx, out_idx_count, out_vtx_count;
  logic [8:0] watermark;
  logic [1:0] out_index_kind;

  dedup_refcount_slot_table u_dut (.*);

  // table shadow
  logic           live_q [drst_pkg::SLOTS];
  logic [31:0]    refs_q [drst_pkg::SLOTS];
  drst_pkg::rec_t rec_q [drst_pkg::SLOTS];
  logic [7:0]     freed_ids [$];
  int             top_mark;

  req_t  pending_items [$];
  resp_t expected_results [$];
  int    errors, cycles, n_results, n_new, n_shared, n_refused, n_freed, n_reads;
  bit    hold_sender;

  function automatic void queue_item(req_t r);
    pending_items.insert(pending_items.size(), r);
  endfunction

  function automatic resp_t table_step(req_t r);
    resp_t o;
    int id;
    logic [7:0] kept [$];
    o = '{st: drst_pkg::ST_IGNORED, id: r.sid, refs: 32'd0, mark: 9'd0,
          rec: '{kind: drst_pkg::KIND_THIRTY_TWO, default: '0}};
    case (r.op)
      drst_pkg::OP_REG: begin
        for (int i = 0; i < top_mark; i++) begin
          if (live_q[i] && rec_q[i] == r.rec) begin
            if (refs_q[i] == drst_pkg::COUNT_MAX) begin
              o.st = drst_pkg::ST_REFUSED; o.id = 8'd0;
            end else begin
              refs_q[i]++;
              o.st = drst_pkg::ST_SHARED; o.id = 8'(i); o.refs = refs_q[i];
            end
            o.mark = 9'(top_mark);
            return o;
          end
        end
        if (freed_ids.size() > 0) begin
          id = freed_ids[$];
          freed_ids.delete(freed_ids.size() - 1);
          if (id >= top_mark) top_mark = id + 1;
        end else if (top_mark >= drst_pkg::SLOTS) begin
          o.st = drst_pkg::ST_REFUSED; o.id = 8'd0; o.mark = 9'(top_mark);
          return o;
        end else begin
          id = top_mark;
          top_mark++;
        end
        live_q[id] = 1'b1; refs_q[id] = 32'd1; rec_q[id] = r.rec;
        o.st = drst_pkg::ST_NEW; o.id = 8'(id); o.refs = 32'd1;
      end
      drst_pkg::OP_UNREG: begin
        if (live_q[r.sid] && refs_q[r.sid] != 0) begin
          refs_q[r.sid]--;
          if (refs_q[r.sid] != 0) begin
            o.st = drst_pkg::ST_RELEASED; o.refs = refs_q[r.sid];
          end else begin
            live_q[r.sid] = 1'b0;
            if (freed_ids.size() < drst_pkg::SLOTS)
              freed_ids.insert(freed_ids.size(), r.sid);
            if (r.sid + 1 == top_mark) begin
              while (top_mark > 0 && !live_q[top_mark-1]) top_mark--;
              foreach (freed_ids[i])
                if (freed_ids[i] < top_mark) kept.insert(kept.size(), freed_ids[i]);
              freed_ids = kept;
            end
            o.st = drst_pkg::ST_FREED;
          end
        end
      end
      drst_pkg::OP_READ: begin
        if (live_q[r.sid]) begin
          o.st = drst_pkg::ST_READ_OK; o.refs = refs_q[r.sid]; o.rec = rec_q[r.sid];
        end else o.st = drst_pkg::ST_READ_DEAD;
      end
      default: ;
    endcase
    o.mark = 9'(top_mark);
    return o;
  endfunction

  function automatic drst_pkg::rec_t rand_rec(bit narrow);
    drst_pkg::rec_t r;
    if (narrow) begin
      r.first_idx = $urandom_range(3); r.idx_count = $urandom_range(2);
      r.vtx_base = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0; r.vtx_count = 32'd7;
      r.segment = 16'($urandom_range(1)); r.kind = 2'($urandom_range(3));
    end else begin
      r = {$urandom, $urandom, $urandom, $urandom, 18'($urandom)};
    end
    return r;
  endfunction

  function automatic req_t mk(drst_pkg::op_t o, drst_pkg::rec_t r, logic [7:0] s);
    req_t q;
    q.op = o; q.rec = r; q.sid = s;
    return q;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts with random gaps
  int gap_left, burst_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0; gap_left <= 0; burst_left <= 4;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0 || hold_sender || pending_items.size() == 0) begin
        in_valid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        req_t r;
        r = pending_items.pop_front();
        expected_results.insert(expected_results.size(), table_step(r));
        in_valid <= 1;
        op <= r.op; first_idx <= r.rec.first_idx; idx_count <= r.rec.idx_count;
        vtx_base <= r.rec.vtx_base; vtx_count <= r.rec.vtx_count;
        segment <= r.rec.segment; index_kind <= r.rec.kind; slot_id <= r.sid;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall pattern and monitor
  logic [5:0] stall_phase;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_stall <= 0; stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_stall <= stall_phase[5] ? 1'b0 : ($urandom_range(0, 2) == 0);
      if (out_valid && !out_stall) begin
        resp_t got;
        got = '{st: drst_pkg::status_t'(status), id: result_id, refs: refs_now,
                mark: watermark,
                rec: '{out_first_idx, out_idx_count, out_vtx_base,
                       out_vtx_count, out_segment, out_index_kind}};
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          errors <= errors + 1;
        end else begin
          resp_t exp_r;
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            errors <= errors + 1;
          end
          case (exp_r.st)
            drst_pkg::ST_NEW: n_new <= n_new + 1;
            drst_pkg::ST_SHARED: n_shared <= n_shared + 1;
            drst_pkg::ST_REFUSED: n_refused <= n_refused + 1;
            drst_pkg::ST_FREED: n_freed <= n_freed + 1;
            drst_pkg::ST_READ_OK: n_reads <= n_reads + 1;
            default: ;
          endcase
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    drst_pkg::rec_t a, b;
    rst = 1; in_valid = 0; out_stall = 0; errors = 0; cycles = 0; n_results = 0;
    n_new = 0; n_shared = 0; n_refused = 0; n_freed = 0; n_reads = 0;
    op = 0; first_idx = 0; idx_count = 0; vtx_base = 0; vtx_count = 0;
    segment = 0; index_kind = 0; slot_id = 0;
    hold_sender = 0; top_mark = 0;
    foreach (live_q[i]) begin
      live_q[i] = 0; refs_q[i] = 0; rec_q[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: extremes, every op and kind, sharing, dead paths
    a = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 2'd3};
    b = '{0, 0, 32'sh7FFF_FFFF, 0, 0, 2'd0};
    queue_item(mk(drst_pkg::OP_READ, a, 8'd0));
    queue_item(mk(drst_pkg::OP_UNREG, a, 8'd255));
    queue_item(mk(drst_pkg::OP_NONE, a, 8'd7));
    queue_item(mk(drst_pkg::OP_REG, a, 8'd0));
    queue_item(mk(drst_pkg::OP_REG, a, 8'd0));
    queue_item(mk(drst_pkg::OP_REG, b, 8'd0));
    for (int k = 1; k <= 2; k++) begin
      b.kind = 2'(k);
      queue_item(mk(drst_pkg::OP_REG, b, 8'd0));
    end
    queue_item(mk(drst_pkg::OP_READ, a, 8'd0));
    queue_item(mk(drst_pkg::OP_READ, a, 8'd3));
    queue_item(mk(drst_pkg::OP_UNREG, a, 8'd0));
    queue_item(mk(drst_pkg::OP_UNREG, a, 8'd1));
    queue_item(mk(drst_pkg::OP_REG, a, 8'd0));
    queue_item(mk(drst_pkg::OP_UNREG, a, 8'd3));
    queue_item(mk(drst_pkg::OP_UNREG, a, 8'd2));
    queue_item(mk(drst_pkg::OP_READ, a, 8'd3));
    queue_item(mk(drst_pkg::OP_REG, b, 8'd0));
    queue_item(mk(drst_pkg::OP_READ, a, 8'd255));

    // sender holds until the table has drained all results
    wait (pending_items.size() == 0 && !(in_valid && in_stall));
    hold_sender = 1;
    wait (expected_results.size() == 0);
    @(posedge clk);
    hold_sender = 0;

    // fill the table to full, then refuse and read around
    for (int i = 0; i < drst_pkg::SLOTS + 2; i++)
      queue_item(mk(drst_pkg::OP_REG, rand_rec(0), 8'd0));
    for (int i = 0; i < 10; i++)
      queue_item(mk(drst_pkg::OP_READ, a, 8'($urandom)));

    // free a run below the top, then the top slot to drop the watermark past it
    for (int i = 200; i < 255; i++)
      queue_item(mk(drst_pkg::OP_UNREG, a, 8'(i)));
    queue_item(mk(drst_pkg::OP_UNREG, a, 8'd255));
    for (int i = 0; i < 30; i++)
      queue_item(mk(drst_pkg::OP_UNREG, a, 8'(i)));

    // random mix on a narrow key space to force sharing
    for (int i = 0; i < 80; i++) begin
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) queue_item(mk(drst_pkg::OP_REG, rand_rec(pick != 0), 8'd0));
      else if (pick < 8)
        queue_item(mk(drst_pkg::OP_UNREG, a, 8'($urandom_range(0, 20))));
      else if (pick < 9)
        queue_item(mk(drst_pkg::OP_READ, a, 8'($urandom_range(0, 24))));
      else queue_item(mk(drst_pkg::op_t'($urandom_range(0, 3)), rand_rec(0),
                         8'($urandom)));
    end

    wait (pending_items.size() == 0 && !(in_valid && in_stall));
    wait (expected_results.size() == 0);
    repeat (600) @(posedge clk);
    $display("results %0d: new %0d shared %0d refused %0d freed %0d reads %0d",
             n_results, n_new, n_shared, n_refused, n_freed, n_reads);
    $display("covered full table, deep sharing, dead reads and watermark shrink");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> files.f
sv/drst_pkg.sv
sv/drst_ctrl.sv
sv/drst_dp.sv
sv/dedup_refcount_slot_table.sv
test/tb_dedup_refcount_slot_table.sv
